// ===== hw/rtl/complex_running_stats_top_macros.svh =====
// Assertion helpers for the running statistics block.
// Each macro expects clk and arst_n in scope.
`ifndef COMPLEX_RUNNING_STATS_TOP_MACROS_SVH
`define COMPLEX_RUNNING_STATS_TOP_MACROS_SVH

// antecedent and consequent in the same cycle
`define CRS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/crs_pkg.sv =====
package crs_pkg;

	// field and format sizes
	localparam int IN_W          = 32;
	localparam int SAMPLE_BITS   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int COUNT_BITS    = 32;
	localparam int NUM_KINDS     = 2;
	localparam int CNT_OUT_W     = 32;
	localparam int KIND_W        = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

	localparam int MEAN_SHIFT = 32 - FRACTION_BITS;
	localparam int MEAN_W     = 48;
	localparam int DIFF_W     = MEAN_W + 1;
	localparam int SUM_W      = DIFF_W + 1;
	localparam int NUMER_W    = DIFF_W - 1;
	localparam int MAG_W      = 64;
	localparam int DEV_W      = 64;
	localparam int PROD_SHIFT = 32;

	// MAC operand split: signed high part, unsigned low part
	localparam int SPLIT_W = (DIFF_W + 1) / 2;
	localparam int HI_W    = DIFF_W - SPLIT_W;
	localparam int PART_W  = SPLIT_W + 1;
	localparam int PP_W    = 2 * PART_W;
	localparam int ACC_W   = 2 * DIFF_W + 2;

	localparam int ITER_W = $clog2(NUMER_W);

	localparam logic signed [63:0] MEAN_MAX64 = (64'sd1 <<< (MEAN_W - 1)) - 64'sd1;
	localparam logic signed [63:0] MEAN_MIN64 = -MEAN_MAX64 - 64'sd1;

	typedef logic signed [IN_W-1:0]   smp_t;
	typedef logic signed [MEAN_W-1:0] mean_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [NUMER_W-1:0]       nmag_t;
	typedef logic [COUNT_BITS-1:0]    cnt_t;
	typedef logic [COUNT_BITS:0]      rem_ext_t;
	typedef logic [CNT_OUT_W-1:0]     cnt_out_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic signed [DEV_W-1:0]  dev_t;
	typedef logic signed [PART_W-1:0] part_t;
	typedef logic signed [PP_W-1:0]   pp_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [KIND_W-1:0]        kind_t;
	typedef logic [ITER_W-1:0]        iter_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIFF,
		ST_MAC_GO,
		ST_MAC_WAIT,
		ST_MINMAX,
		ST_DIV_WAIT,
		ST_MEAN,
		ST_TDIFF,
		ST_M2RE,
		ST_M2IM,
		ST_OUT
	} state_t;

	// product terms run through the shared MAC
	typedef enum logic [2:0] {
		T_RR,
		T_II,
		T_DRTR,
		T_DITI,
		T_DITR,
		T_DRTI
	} term_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic sub;
	} mac_ctl_t;

	function automatic smp_t sat_sample(smp_t v);
		smp_t smax;
		smp_t smin;
		smax = smp_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		smin = -smax - smp_t'(1);
		if (v > smax) begin
			return smax;
		end
		if (v < smin) begin
			return smin;
		end
		return v;
	endfunction

	// Q16.16 -> Q16.32 with saturation to the mean width
	function automatic mean_t to_mean(smp_t v);
		logic signed [63:0] w;
		w = v;
		w = w <<< MEAN_SHIFT;
		if (w > MEAN_MAX64) begin
			return mean_t'(MEAN_MAX64);
		end
		if (w < MEAN_MIN64) begin
			return mean_t'(MEAN_MIN64);
		end
		return mean_t'(w);
	endfunction

	function automatic mean_t sat_mean(sum_t v);
		if (v > sum_t'(MEAN_MAX64)) begin
			return mean_t'(MEAN_MAX64);
		end
		if (v < sum_t'(MEAN_MIN64)) begin
			return mean_t'(MEAN_MIN64);
		end
		return mean_t'(v);
	endfunction

	// floor shift of the product sum, saturated to DEV_W
	function automatic dev_t shift_sat(acc_t a);
		logic [ACC_W-PROD_SHIFT-1:0] s;
		s = a[ACC_W-1:PROD_SHIFT];
		if (s[ACC_W-PROD_SHIFT-1:DEV_W-1] == '0 || s[ACC_W-PROD_SHIFT-1:DEV_W-1] == '1) begin
			return dev_t'(s[DEV_W-1:0]);
		end
		return a[ACC_W-1] ? dev_t'({1'b1, {(DEV_W-1){1'b0}}})
			: dev_t'({1'b0, {(DEV_W-1){1'b1}}});
	endfunction

	function automatic dev_t sat_dev_add(dev_t a, dev_t b);
		dev_t r;
		r = a + b;
		if (a[DEV_W-1] == b[DEV_W-1] && r[DEV_W-1] != a[DEV_W-1]) begin
			return a[DEV_W-1] ? dev_t'({1'b1, {(DEV_W-1){1'b0}}})
				: dev_t'({1'b0, {(DEV_W-1){1'b1}}});
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/complex_running_stats_top.sv =====
// Complex running statistics (Welford mean and complex M2), one set per correlation kind.
// One item in flight: in_stall is high from acceptance until the result is loaded.
// Steps per item: 48-step restoring divider (magnitude products run beside it), then
//   four M2 products of four partial products each on the shared MAC.
// Reset (arst_n low, asynchronous): all statistics sets cleared, least magnitude all ones,
//   matrix_mode 0, no result pending; no clearing pass, ready right after reset.
module complex_running_stats_top (
	input  logic        clk,
	input  logic        arst_n,

	// configuration: matrix_mode
	input  logic        cfg_we,
	input  logic        cfg_wdata,

	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        corr_kind,
	input  logic [31:0] xx_re,
	input  logic [31:0] xx_im,
	input  logic [31:0] yy_re,
	input  logic [31:0] yy_im,
	input  logic        block_end,

	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind_out,
	output logic [31:0] sample_count,
	output logic [31:0] min_re,
	output logic [31:0] min_im,
	output logic [31:0] max_re,
	output logic [31:0] max_im,
	output logic [47:0] mean_re,
	output logic [47:0] mean_im,
	output logic [63:0] m2_re,
	output logic [63:0] m2_im,
	output logic [31:0] zero_count,
	output logic        block_done
);

	`include "complex_running_stats_top_macros.svh"

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	crs_pkg::state_t   state_q, state_d;
	crs_pkg::term_t    term_q, term_d;
	crs_pkg::mac_ctl_t mac_ctl;
	logic              div_start;
	logic              out_load;
	logic              matrix_mode_q;

	// ------------------------------------------------------------------
	// Per-kind statistics sets (two entries each, flops)
	// ------------------------------------------------------------------
	crs_pkg::cnt_t  count_q   [crs_pkg::NUM_KINDS];
	crs_pkg::cnt_t  zero_q    [crs_pkg::NUM_KINDS];
	crs_pkg::smp_t  min_re_q  [crs_pkg::NUM_KINDS];
	crs_pkg::smp_t  min_im_q  [crs_pkg::NUM_KINDS];
	crs_pkg::smp_t  max_re_q  [crs_pkg::NUM_KINDS];
	crs_pkg::smp_t  max_im_q  [crs_pkg::NUM_KINDS];
	crs_pkg::mag_t  least_q   [crs_pkg::NUM_KINDS];
	crs_pkg::mag_t  most_q    [crs_pkg::NUM_KINDS];
	crs_pkg::mean_t mean_re_q [crs_pkg::NUM_KINDS];
	crs_pkg::mean_t mean_im_q [crs_pkg::NUM_KINDS];
	crs_pkg::dev_t  dev_re_q  [crs_pkg::NUM_KINDS];
	crs_pkg::dev_t  dev_im_q  [crs_pkg::NUM_KINDS];

	// ------------------------------------------------------------------
	// Working registers of the item in flight
	// ------------------------------------------------------------------
	crs_pkg::kind_t kind_q;
	logic           blk_q;
	crs_pkg::smp_t  s_re_q, s_im_q;   // sample after half sum (matrix mode) and clamp
	crs_pkg::mean_t xr_q, xi_q;       // sample in Q16.32
	crs_pkg::diff_t dr_q, di_q;       // sample minus old mean
	crs_pkg::diff_t tr_q, ti_q;       // sample minus new mean
	crs_pkg::cnt_t  cnt_new_q;        // saturated count, also the divisor

	// output register
	logic             out_valid_q;
	logic             o_kind_q;
	crs_pkg::cnt_out_t o_count_q, o_zero_q;
	crs_pkg::smp_t    o_min_re_q, o_min_im_q, o_max_re_q, o_max_im_q;
	crs_pkg::mean_t   o_mean_re_q, o_mean_im_q;
	crs_pkg::dev_t    o_m2_re_q, o_m2_im_q;
	logic             o_blk_q;

	// shared units
	crs_pkg::diff_t mac_a, mac_b;
	crs_pkg::acc_t  mac_acc;
	logic           mac_busy;
	crs_pkg::diff_t div_q_re, div_q_im;
	logic           div_busy;

	// ------------------------------------------------------------------
	// Input decode: set select and sample formation
	// ------------------------------------------------------------------
	crs_pkg::kind_t kind_sel;
	crs_pkg::smp_t  smp_re, smp_im;
	logic [32:0]    sum_re, sum_im;
	crs_pkg::mag_t  mag;

	always_comb begin
		// kinds beyond the configured set count fold onto the last set
		if (int'(corr_kind) >= crs_pkg::NUM_KINDS) begin
			kind_sel = crs_pkg::kind_t'(crs_pkg::NUM_KINDS - 1);
		end else begin
			kind_sel = crs_pkg::kind_t'(corr_kind);
		end

		// matrix mode: floor((XX + YY) / 2)
		sum_re = {xx_re[31], xx_re} + {yy_re[31], yy_re};
		sum_im = {xx_im[31], xx_im} + {yy_im[31], yy_im};
		if (matrix_mode_q) begin
			smp_re = crs_pkg::sat_sample(crs_pkg::smp_t'(sum_re[32:1]));
			smp_im = crs_pkg::sat_sample(crs_pkg::smp_t'(sum_im[32:1]));
		end else begin
			smp_re = crs_pkg::sat_sample(crs_pkg::smp_t'(xx_re));
			smp_im = crs_pkg::sat_sample(crs_pkg::smp_t'(xx_im));
		end
	end

	// squared magnitude comes out of the MAC after the T_II term
	assign mag = crs_pkg::mag_t'(mac_acc[crs_pkg::MAG_W-1:0]);

	// ------------------------------------------------------------------
	// MAC operand decode
	// ------------------------------------------------------------------
	always_comb begin
		unique case (term_q)
			crs_pkg::T_RR: begin
				mac_a = crs_pkg::diff_t'(s_re_q);
				mac_b = crs_pkg::diff_t'(s_re_q);
			end
			crs_pkg::T_II: begin
				mac_a = crs_pkg::diff_t'(s_im_q);
				mac_b = crs_pkg::diff_t'(s_im_q);
			end
			crs_pkg::T_DRTR: begin
				mac_a = dr_q;
				mac_b = tr_q;
			end
			crs_pkg::T_DITI: begin
				mac_a = di_q;
				mac_b = ti_q;
			end
			crs_pkg::T_DITR: begin
				mac_a = di_q;
				mac_b = tr_q;
			end
			crs_pkg::T_DRTI: begin
				mac_a = dr_q;
				mac_b = ti_q;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: next state and strobes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crs_pkg::ST_IDLE;
			term_q  <= crs_pkg::T_RR;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		term_d    = term_q;
		mac_ctl   = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		in_stall  = 1'b1;
		unique case (state_q)
			crs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = crs_pkg::ST_PREP;
				end
			end
			crs_pkg::ST_PREP: begin
				state_d = crs_pkg::ST_DIFF;
			end
			crs_pkg::ST_DIFF: begin
				term_d  = crs_pkg::T_RR;
				state_d = crs_pkg::ST_MAC_GO;
			end
			crs_pkg::ST_MAC_GO: begin
				mac_ctl.start = 1'b1;
				mac_ctl.clear = (term_q == crs_pkg::T_RR) || (term_q == crs_pkg::T_DRTR)
					|| (term_q == crs_pkg::T_DITR);
				mac_ctl.sub   = (term_q == crs_pkg::T_DRTI);
				// divider runs alongside the magnitude products
				div_start     = (term_q == crs_pkg::T_RR);
				state_d       = crs_pkg::ST_MAC_WAIT;
			end
			crs_pkg::ST_MAC_WAIT: begin
				if (!mac_busy) begin
					unique case (term_q)
						crs_pkg::T_RR: begin
							term_d  = crs_pkg::T_II;
							state_d = crs_pkg::ST_MAC_GO;
						end
						crs_pkg::T_II:   state_d = crs_pkg::ST_MINMAX;
						crs_pkg::T_DRTR: begin
							term_d  = crs_pkg::T_DITI;
							state_d = crs_pkg::ST_MAC_GO;
						end
						crs_pkg::T_DITI: state_d = crs_pkg::ST_M2RE;
						crs_pkg::T_DITR: begin
							term_d  = crs_pkg::T_DRTI;
							state_d = crs_pkg::ST_MAC_GO;
						end
						crs_pkg::T_DRTI: state_d = crs_pkg::ST_M2IM;
						default:         state_d = crs_pkg::ST_IDLE;
					endcase
				end
			end
			crs_pkg::ST_MINMAX: begin
				state_d = crs_pkg::ST_DIV_WAIT;
			end
			crs_pkg::ST_DIV_WAIT: begin
				if (!div_busy) begin
					state_d = crs_pkg::ST_MEAN;
				end
			end
			crs_pkg::ST_MEAN: begin
				state_d = crs_pkg::ST_TDIFF;
			end
			crs_pkg::ST_TDIFF: begin
				term_d  = crs_pkg::T_DRTR;
				state_d = crs_pkg::ST_MAC_GO;
			end
			crs_pkg::ST_M2RE: begin
				term_d  = crs_pkg::T_DITR;
				state_d = crs_pkg::ST_MAC_GO;
			end
			crs_pkg::ST_M2IM: begin
				state_d = crs_pkg::ST_OUT;
			end
			crs_pkg::ST_OUT: begin
				// wait for the output register to free up
				if (!(out_valid_q && out_stall)) begin
					out_load = 1'b1;
					state_d  = crs_pkg::ST_IDLE;
				end
			end
			default: state_d = crs_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Statistics sets, config register, output valid
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_mode_q <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int k = 0; k < crs_pkg::NUM_KINDS; k++) begin
				count_q[k]   <= '0;
				zero_q[k]    <= '0;
				min_re_q[k]  <= '0;
				min_im_q[k]  <= '0;
				max_re_q[k]  <= '0;
				max_im_q[k]  <= '0;
				least_q[k]   <= '1;
				most_q[k]    <= '0;
				mean_re_q[k] <= '0;
				mean_im_q[k] <= '0;
				dev_re_q[k]  <= '0;
				dev_im_q[k]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				matrix_mode_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				crs_pkg::ST_MINMAX: begin
					count_q[kind_q] <= cnt_new_q;
					if (mag == '0 && zero_q[kind_q] != '1) begin
						zero_q[kind_q] <= zero_q[kind_q] + crs_pkg::cnt_t'(1);
					end
					// first sample of a set always becomes the greatest; ties keep the older
					if (count_q[kind_q] == '0 || mag > most_q[kind_q]) begin
						most_q[kind_q]   <= mag;
						max_re_q[kind_q] <= s_re_q;
						max_im_q[kind_q] <= s_im_q;
					end
					if (mag < least_q[kind_q]) begin
						least_q[kind_q]  <= mag;
						min_re_q[kind_q] <= s_re_q;
						min_im_q[kind_q] <= s_im_q;
					end
				end
				crs_pkg::ST_MEAN: begin
					mean_re_q[kind_q] <= crs_pkg::sat_mean(
						crs_pkg::sum_t'(mean_re_q[kind_q]) + crs_pkg::sum_t'(div_q_re));
					mean_im_q[kind_q] <= crs_pkg::sat_mean(
						crs_pkg::sum_t'(mean_im_q[kind_q]) + crs_pkg::sum_t'(div_q_im));
				end
				crs_pkg::ST_M2RE: begin
					dev_re_q[kind_q] <= crs_pkg::sat_dev_add(dev_re_q[kind_q],
						crs_pkg::shift_sat(mac_acc));
				end
				crs_pkg::ST_M2IM: begin
					dev_im_q[kind_q] <= crs_pkg::sat_dev_add(dev_im_q[kind_q],
						crs_pkg::shift_sat(mac_acc));
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Working and output registers (no reset needed)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == crs_pkg::ST_IDLE && in_valid) begin
			kind_q <= kind_sel;
			blk_q  <= block_end;
			s_re_q <= smp_re;
			s_im_q <= smp_im;
		end
		if (state_q == crs_pkg::ST_PREP) begin
			xr_q <= crs_pkg::to_mean(s_re_q);
			xi_q <= crs_pkg::to_mean(s_im_q);
		end
		if (state_q == crs_pkg::ST_DIFF) begin
			dr_q      <= crs_pkg::diff_t'(xr_q) - crs_pkg::diff_t'(mean_re_q[kind_q]);
			di_q      <= crs_pkg::diff_t'(xi_q) - crs_pkg::diff_t'(mean_im_q[kind_q]);
			cnt_new_q <= (count_q[kind_q] == '1) ? count_q[kind_q]
				: count_q[kind_q] + crs_pkg::cnt_t'(1);
		end
		if (state_q == crs_pkg::ST_TDIFF) begin
			tr_q <= crs_pkg::diff_t'(xr_q) - crs_pkg::diff_t'(mean_re_q[kind_q]);
			ti_q <= crs_pkg::diff_t'(xi_q) - crs_pkg::diff_t'(mean_im_q[kind_q]);
		end
		if (out_load) begin
			o_kind_q    <= kind_q[0];
			o_count_q   <= crs_pkg::cnt_out_t'(count_q[kind_q]);
			o_zero_q    <= crs_pkg::cnt_out_t'(zero_q[kind_q]);
			o_min_re_q  <= min_re_q[kind_q];
			o_min_im_q  <= min_im_q[kind_q];
			o_max_re_q  <= max_re_q[kind_q];
			o_max_im_q  <= max_im_q[kind_q];
			o_mean_re_q <= mean_re_q[kind_q];
			o_mean_im_q <= mean_im_q[kind_q];
			o_m2_re_q   <= dev_re_q[kind_q];
			o_m2_im_q   <= dev_im_q[kind_q];
			o_blk_q     <= blk_q;
		end
	end

	// ------------------------------------------------------------------
	// Shared arithmetic units
	// ------------------------------------------------------------------
	crs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	crs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_re (dr_q),
		.num_im (di_q),
		.den    (cnt_new_q),
		.q_re   (div_q_re),
		.q_im   (div_q_im),
		.busy   (div_busy)
	);

	// ------------------------------------------------------------------
	// Ports
	// ------------------------------------------------------------------
	assign out_valid    = out_valid_q;
	assign kind_out     = o_kind_q;
	assign sample_count = o_count_q;
	assign zero_count   = o_zero_q;
	assign min_re       = o_min_re_q;
	assign min_im       = o_min_im_q;
	assign max_re       = o_max_re_q;
	assign max_im       = o_max_im_q;
	assign mean_re      = o_mean_re_q;
	assign mean_im      = o_mean_im_q;
	assign m2_re        = o_m2_re_q;
	assign m2_im        = o_m2_im_q;
	assign block_done   = o_blk_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`CRS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted but block not busy")
	`CRS_ASSERT_SAME(a_out_from_seq, $rose(out_valid_q), $past(state_q) == crs_pkg::ST_OUT, "result raised outside output step")
	`CRS_ASSERT_SAME(a_div_done_at_mean, state_q == crs_pkg::ST_MEAN, !div_busy, "mean update while divider running")
	`CRS_ASSERT_SAME(a_mac_idle_on_start, mac_ctl.start, !mac_busy, "MAC started while busy")

endmodule

// ===== hw/rtl/crs_mac.sv =====
// Shared multiply-accumulate: one signed DIFF_W x DIFF_W product per start,
// four partial products, one per cycle, registered before accumulation.
module crs_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  crs_pkg::mac_ctl_t ctl,
	input  crs_pkg::diff_t    op_a,
	input  crs_pkg::diff_t    op_b,
	output crs_pkg::acc_t     acc,
	output logic              busy
);

	crs_pkg::diff_t a_q;
	crs_pkg::diff_t b_q;
	logic           sub_q;
	logic [1:0]     step_q;
	logic           run_q;

	crs_pkg::pp_t   pp_s1;
	logic [1:0]     sh_s1;
	logic           sub_s1;
	logic           vld_s1;

	crs_pkg::acc_t  acc_q;

	logic signed [crs_pkg::HI_W-1:0] a_hi;
	logic signed [crs_pkg::HI_W-1:0] b_hi;
	crs_pkg::part_t a_part;
	crs_pkg::part_t b_part;
	crs_pkg::pp_t   pp;
	crs_pkg::acc_t  pp_ext;
	crs_pkg::acc_t  addend;

	always_comb begin
		a_hi   = a_q[crs_pkg::DIFF_W-1:crs_pkg::SPLIT_W];
		b_hi   = b_q[crs_pkg::DIFF_W-1:crs_pkg::SPLIT_W];
		a_part = step_q[0] ? crs_pkg::part_t'(a_hi)
			: crs_pkg::part_t'({1'b0, a_q[crs_pkg::SPLIT_W-1:0]});
		b_part = step_q[1] ? crs_pkg::part_t'(b_hi)
			: crs_pkg::part_t'({1'b0, b_q[crs_pkg::SPLIT_W-1:0]});
		pp     = crs_pkg::pp_t'(a_part) * crs_pkg::pp_t'(b_part);
	end

	always_comb begin
		pp_ext = crs_pkg::acc_t'(pp_s1);
		case (sh_s1)
			2'd0:    addend = pp_ext;
			2'd1:    addend = pp_ext <<< crs_pkg::SPLIT_W;
			2'd2:    addend = pp_ext <<< (2 * crs_pkg::SPLIT_W);
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			step_q <= 2'd0;
		end else begin
			vld_s1 <= run_q;
			if (ctl.start) begin
				run_q  <= 1'b1;
				step_q <= 2'd0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			sub_q <= ctl.sub;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end
		if (run_q) begin
			pp_s1  <= pp;
			sh_s1  <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
			sub_s1 <= sub_q;
		end
		if (vld_s1) begin
			acc_q <= sub_s1 ? acc_q - addend : acc_q + addend;
		end
	end

	assign acc  = acc_q;
	assign busy = run_q | vld_s1;

endmodule

// ===== hw/rtl/crs_div.sv =====
// Two-lane restoring divider, one quotient bit per cycle per lane,
// truncating toward zero; a final step applies the sign.
module crs_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  crs_pkg::diff_t num_re,
	input  crs_pkg::diff_t num_im,
	input  crs_pkg::cnt_t  den,
	output crs_pkg::diff_t q_re,
	output crs_pkg::diff_t q_im,
	output logic           busy
);

	crs_pkg::nmag_t     numsh_q [2];
	crs_pkg::nmag_t     quo_q   [2];
	crs_pkg::cnt_t      rem_q   [2];
	logic               neg_q   [2];
	crs_pkg::diff_t     q_q     [2];
	crs_pkg::cnt_t      den_q;
	crs_pkg::iter_t     iter_q;
	logic               run_q;
	logic               fix_q;

	crs_pkg::diff_t     num_in [2];
	crs_pkg::rem_ext_t  trial  [2];
	logic               fits   [2];

	assign num_in[0] = num_re;
	assign num_in[1] = num_im;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_q[l], numsh_q[l][crs_pkg::NUMER_W-1]};
			fits[l]  = trial[l] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			iter_q <= '0;
		end else begin
			fix_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + crs_pkg::iter_t'(1);
				if (iter_q == crs_pkg::iter_t'(crs_pkg::NUMER_W - 1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int l = 0; l < 2; l++) begin
				neg_q[l]   <= num_in[l][crs_pkg::DIFF_W-1];
				numsh_q[l] <= num_in[l][crs_pkg::DIFF_W-1]
					? crs_pkg::nmag_t'(-num_in[l]) : crs_pkg::nmag_t'(num_in[l]);
				rem_q[l]   <= '0;
				quo_q[l]   <= '0;
			end
		end else if (run_q) begin
			for (int l = 0; l < 2; l++) begin
				numsh_q[l] <= numsh_q[l] << 1;
				rem_q[l]   <= fits[l] ? crs_pkg::cnt_t'(trial[l] - {1'b0, den_q})
					: crs_pkg::cnt_t'(trial[l]);
				quo_q[l]   <= {quo_q[l][crs_pkg::NUMER_W-2:0], fits[l]};
			end
		end
		if (fix_q) begin
			for (int l = 0; l < 2; l++) begin
				q_q[l] <= neg_q[l] ? -crs_pkg::diff_t'(quo_q[l]) : crs_pkg::diff_t'(quo_q[l]);
			end
		end
	end

	assign q_re = q_q[0];
	assign q_im = q_q[1];
	assign busy = run_q | fix_q;

endmodule

// ===== tb/complex_running_stats_top_tb.sv =====
module complex_running_stats_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// set select and sample-forming mode, written by name in the directed tests
	typedef enum bit {KIND_CROSS = 1'b0, KIND_AUTO = 1'b1} corr_kind_e;
	typedef enum bit {MODE_PLAIN = 1'b0, MODE_MATRIX = 1'b1} mix_mode_e;

	// Q16.16 corner values
	localparam logic [31:0] S_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S_MIN = 32'h8000_0000;
	localparam logic [31:0] S_ONE = 32'h0001_0000;

	// saturation bounds, held wide so no intermediate sum can wrap
	localparam logic signed [127:0] MEAN_HI = (128'sd1 <<< (crs_pkg::MEAN_W - 1)) - 128'sd1;
	localparam logic signed [127:0] MEAN_LO = -(128'sd1 <<< (crs_pkg::MEAN_W - 1));
	localparam logic signed [127:0] DEV_HI  = (128'sd1 <<< (crs_pkg::DEV_W - 1)) - 128'sd1;
	localparam logic signed [127:0] DEV_LO  = -(128'sd1 <<< (crs_pkg::DEV_W - 1));

	// one result item, bit for bit as it appears on the ports
	typedef struct packed {
		logic        kind;
		logic [31:0] count;
		logic [31:0] min_re;
		logic [31:0] min_im;
		logic [31:0] max_re;
		logic [31:0] max_im;
		logic [47:0] mean_re;
		logic [47:0] mean_im;
		logic [63:0] m2_re;
		logic [63:0] m2_im;
		logic [31:0] zeros;
		logic        done;
	} stats_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic        cfg_wdata  = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        corr_kind  = 1'b0;
	logic [31:0] xx_re      = '0;
	logic [31:0] xx_im      = '0;
	logic [31:0] yy_re      = '0;
	logic [31:0] yy_im      = '0;
	logic        block_end  = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic        kind_out;
	logic [31:0] sample_count;
	logic [31:0] min_re;
	logic [31:0] min_im;
	logic [31:0] max_re;
	logic [31:0] max_im;
	logic [47:0] mean_re;
	logic [47:0] mean_im;
	logic [63:0] m2_re;
	logic [63:0] m2_im;
	logic [31:0] zero_count;
	logic        block_done;

	complex_running_stats_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.corr_kind    (corr_kind),
		.xx_re        (xx_re),
		.xx_im        (xx_im),
		.yy_re        (yy_re),
		.yy_im        (yy_im),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind_out     (kind_out),
		.sample_count (sample_count),
		.min_re       (min_re),
		.min_im       (min_im),
		.max_re       (max_re),
		.max_im       (max_im),
		.mean_re      (mean_re),
		.mean_im      (mean_im),
		.m2_re        (m2_re),
		.m2_im        (m2_im),
		.zero_count   (zero_count),
		.block_done   (block_done)
	);

	// ---------------------------------------------------------------
	// Predictor state: one statistics set per correlation kind, plus
	// our copy of matrix_mode. Updated in item acceptance order.
	// ---------------------------------------------------------------
	logic [31:0]        n_seen [2];
	logic [31:0]        n_zero [2];
	logic [31:0]        lo_re  [2];
	logic [31:0]        lo_im  [2];
	logic [31:0]        hi_re  [2];
	logic [31:0]        hi_im  [2];
	logic [63:0]        lo_mag [2];
	logic [63:0]        hi_mag [2];
	logic signed [47:0] avg_re [2];
	logic signed [47:0] avg_im [2];
	logic signed [63:0] dev_re [2];
	logic signed [63:0] dev_im [2];
	mix_mode_e          mode_now;

	stats_t expected_stats[$];
	int     error_count   = 0;
	int     snd_idle_pct  = 0;  // chance per cycle that the sender holds off
	int     rcv_stall_pct = 0;  // chance per cycle that the receiver stalls
	logic [31:0] prev_re  = '0; // last random sample, reused for magnitude ties
	logic [31:0] prev_im  = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("complex_running_stats_top_tb: done, errors");
		$finish;
	end

	// receiver back-pressure, changed only on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
	end

	function automatic logic signed [127:0] clip(input logic signed [127:0] v,
		input logic signed [127:0] lo, input logic signed [127:0] hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	task automatic clear_stats();
		for (int k = 0; k < 2; k++) begin
			n_seen[k] = '0;
			n_zero[k] = '0;
			lo_re[k]  = '0;
			lo_im[k]  = '0;
			hi_re[k]  = '0;
			hi_im[k]  = '0;
			lo_mag[k] = '1;   // first sample always beats it
			hi_mag[k] = '0;
			avg_re[k] = '0;
			avg_im[k] = '0;
			dev_re[k] = '0;
			dev_im[k] = '0;
		end
		mode_now = MODE_PLAIN;
	endtask

	// Fold one sample into its set and return the set as the block
	// should report it.
	function automatic stats_t fold_sample(input corr_kind_e kind,
		input logic [31:0] xre, input logic [31:0] xim,
		input logic [31:0] yre, input logic [31:0] yim, input logic blk_end);
		int k;
		logic signed [63:0]  re;
		logic signed [63:0]  im;
		logic [63:0]         mag;
		logic [31:0]         cnt_old;
		logic signed [127:0] cnt;
		logic signed [127:0] xr;
		logic signed [127:0] xi;
		logic signed [127:0] dr;
		logic signed [127:0] di;
		logic signed [127:0] tr;
		logic signed [127:0] ti;
		logic signed [127:0] mr;
		logic signed [127:0] mi;
		logic signed [127:0] prod;
		logic signed [127:0] acc;
		stats_t s;

		k  = int'(kind);
		re = $signed(xre);
		im = $signed(xim);
		// half sum floors; it always fits the 32-bit sample range
		if (mode_now == MODE_MATRIX) begin
			re = (re + $signed(yre)) >>> 1;
			im = (im + $signed(yim)) >>> 1;
		end

		// squared magnitude tops out at 2^63, so compare unsigned
		mag = re * re + im * im;
		cnt_old = n_seen[k];
		if (cnt_old != '1) begin
			n_seen[k] = cnt_old + 32'd1;
		end
		if (mag == '0 && n_zero[k] != '1) begin
			n_zero[k] = n_zero[k] + 32'd1;
		end
		// first sample wins the max even at zero; ties keep the older one
		if (cnt_old == '0 || mag > hi_mag[k]) begin
			hi_mag[k] = mag;
			hi_re[k]  = re[31:0];
			hi_im[k]  = im[31:0];
		end
		if (mag < lo_mag[k]) begin
			lo_mag[k] = mag;
			lo_re[k]  = re[31:0];
			lo_im[k]  = im[31:0];
		end

		// Welford mean in Q16.32, division truncating toward zero
		cnt = {96'd0, n_seen[k]};
		xr  = re <<< crs_pkg::MEAN_SHIFT;
		xi  = im <<< crs_pkg::MEAN_SHIFT;
		dr  = xr - avg_re[k];
		di  = xi - avg_im[k];
		mr  = clip(avg_re[k] + dr / cnt, MEAN_LO, MEAN_HI);
		mi  = clip(avg_im[k] + di / cnt, MEAN_LO, MEAN_HI);
		avg_re[k] = mr[47:0];
		avg_im[k] = mi[47:0];
		tr  = xr - mr;
		ti  = xi - mi;

		// complex M2, products floored to Q32.32 then saturating add
		prod = dr * tr + di * ti;
		acc  = clip(dev_re[k] + clip(prod >>> crs_pkg::PROD_SHIFT, DEV_LO, DEV_HI),
			DEV_LO, DEV_HI);
		dev_re[k] = acc[63:0];
		prod = di * tr - dr * ti;
		acc  = clip(dev_im[k] + clip(prod >>> crs_pkg::PROD_SHIFT, DEV_LO, DEV_HI),
			DEV_LO, DEV_HI);
		dev_im[k] = acc[63:0];

		s.kind    = kind;
		s.count   = n_seen[k];
		s.min_re  = lo_re[k];
		s.min_im  = lo_im[k];
		s.max_re  = hi_re[k];
		s.max_im  = hi_im[k];
		s.mean_re = avg_re[k];
		s.mean_im = avg_im[k];
		s.m2_re   = dev_re[k];
		s.m2_im   = dev_im[k];
		s.zeros   = n_zero[k];
		s.done    = blk_end;
		return s;
	endfunction

	// ---------------------------------------------------------------
	// Sender side. Payload changes on the falling edge only; an item
	// counts as taken at the rising edge where in_stall is low.
	// ---------------------------------------------------------------
	task automatic send_item(input corr_kind_e kind, input logic [31:0] xre,
		input logic [31:0] xim, input logic [31:0] yre, input logic [31:0] yim,
		input logic blk_end);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < snd_idle_pct) begin
			gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		corr_kind <= kind;
		xx_re     <= xre;
		xx_im     <= xim;
		yy_re     <= yre;
		yy_im     <= yim;
		block_end <= blk_end;
		do begin
			@(posedge clk);
		end while (in_stall);
		expected_stats.push_back(fold_sample(kind, xre, xim, yre, yim, blk_end));
	endtask

	// drop valid and hold off until every pending result is back
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_stats.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// register write only with the block drained; every item has a
	// result, so an empty queue means the block is idle
	task automatic set_matrix_mode(input mix_mode_e mode);
		wait_all_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_now = mode;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			6: return $urandom_range(0, 32'h7ffff) - 32'h40000;
			7: begin
				case ($urandom_range(0, 4))
					0: return S_MAX;
					1: return S_MIN;
					2: return 32'h0;
					3: return 32'hffff_ffff;
					default: return 32'h1;
				endcase
			end
			default: return $urandom_range(0, 32'h1ffffff) - 32'h1000000;
		endcase
	endfunction

	// random sample with a fair share of zero samples and magnitude ties
	task automatic send_random_item();
		logic [31:0] xre;
		logic [31:0] xim;
		logic [31:0] yre;
		logic [31:0] yim;
		xre = pick_value();
		xim = pick_value();
		yre = pick_value();
		yim = pick_value();
		if ($urandom_range(0, 9) == 0) begin
			if (mode_now == MODE_MATRIX) begin
				yre = -xre;
				yim = -xim;
			end else begin
				xre = '0;
				xim = '0;
			end
		end else if (mode_now == MODE_PLAIN && $urandom_range(0, 9) == 0) begin
			// quarter turn of the previous sample: same magnitude
			xre = -prev_im;
			xim = prev_re;
		end
		prev_re = xre;
		prev_im = xim;
		send_item(corr_kind_e'($urandom_range(0, 1)), xre, xim, yre, yim,
			$urandom_range(0, 7) == 0);
	endtask

	// ---------------------------------------------------------------
	// Result checker: every taken result against the oldest prediction.
	// ---------------------------------------------------------------
	task automatic check_field(input string fname, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, fname, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		stats_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_stats.size() == 0) begin
				$display("%0t ns: result with no item pending, count %h", $time,
					sample_count);
				error_count++;
			end else begin
				want = expected_stats.pop_front();
				check_field("kind_out",     want.kind,    kind_out);
				check_field("sample_count", want.count,   sample_count);
				check_field("min_re",       want.min_re,  min_re);
				check_field("min_im",       want.min_im,  min_im);
				check_field("max_re",       want.max_re,  max_re);
				check_field("max_im",       want.max_im,  max_im);
				check_field("mean_re",      want.mean_re, mean_re);
				check_field("mean_im",      want.mean_im, mean_im);
				check_field("m2_re",        want.m2_re,   m2_re);
				check_field("m2_im",        want.m2_im,   m2_im);
				check_field("zero_count",   want.zeros,   zero_count);
				check_field("block_done",   want.done,    block_done);
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// plain samples: zero first sample, ties, extreme magnitudes, yy ignored
	task automatic test_plain_extremes();
		set_matrix_mode(MODE_PLAIN);
		// zero first sample still takes the max slot; yy must not matter
		send_item(KIND_CROSS, 32'h0, 32'h0, S_MAX, S_MIN, 1'b0);
		send_item(KIND_CROSS, S_ONE, 32'h0, 32'h0, 32'h0, 1'b0);
		// equal magnitudes: older max stays
		send_item(KIND_CROSS, -S_ONE, 32'h0, S_MIN, S_MAX, 1'b0);
		send_item(KIND_CROSS, 32'h0, S_ONE, 32'h0, 32'h0, 1'b1);
		send_item(KIND_AUTO, S_MAX, S_MIN, 32'h0, 32'h0, 1'b0);
		// 2^63 squared magnitude, top bit of the compare
		send_item(KIND_AUTO, S_MIN, S_MIN, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		send_item(KIND_AUTO, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		send_item(KIND_AUTO, S_MIN, S_MAX, 32'h0, 32'h0, 1'b1);
		send_item(KIND_CROSS, S_MAX, S_MAX, 32'h0, 32'h0, 1'b0);
		send_item(KIND_CROSS, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0);
		send_item(KIND_CROSS, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 1'b1);
	endtask

	// matrix mode: half sum floors, extremes, sums that cancel to zero
	task automatic test_matrix_half_sum();
		set_matrix_mode(MODE_MATRIX);
		send_item(KIND_CROSS, 32'd3, -32'd3, 32'h0, 32'h0, 1'b0);
		send_item(KIND_CROSS, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0);
		send_item(KIND_AUTO, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
		send_item(KIND_AUTO, 32'd5, -32'd5, -32'd5, 32'd5, 1'b0);
		send_item(KIND_CROSS, -32'd1, 32'd1, 32'h0, 32'h0, 1'b0);
		// max plus min is -1: floor of half is -1
		send_item(KIND_AUTO, S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
		send_item(KIND_CROSS, S_ONE, -S_ONE, S_ONE, -S_ONE, 1'b1);
	endtask

	task automatic test_random_stream(input int n, input mix_mode_e mode,
		input int idle_pct, input int stall_pct);
		set_matrix_mode(mode);
		snd_idle_pct  = idle_pct;
		rcv_stall_pct = stall_pct;
		repeat (n) send_random_item();
		wait_all_results();
	endtask

	// sender drains the block between short bursts
	task automatic test_sender_pause();
		set_matrix_mode(MODE_PLAIN);
		snd_idle_pct  = 0;
		rcv_stall_pct = 50;
		repeat (8) begin
			repeat (5) send_random_item();
			wait_all_results();
		end
	endtask

	initial begin
		clear_stats();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_extremes();
		test_matrix_half_sum();

		// idling phases, each in both sample modes
		test_random_stream(220, MODE_PLAIN,  0,  0);
		test_random_stream(220, MODE_MATRIX, 0,  0);
		test_random_stream(220, MODE_PLAIN,  50, 0);
		test_random_stream(220, MODE_MATRIX, 50, 0);
		test_random_stream(220, MODE_MATRIX, 0,  50);
		test_random_stream(220, MODE_PLAIN,  0,  50);
		test_random_stream(220, MODE_PLAIN,  9,  9);
		test_random_stream(220, MODE_MATRIX, 9,  9);

		test_sender_pause();

		wait_all_results();
		// quiet window to catch any stray result
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("complex_running_stats_top_tb: done, clean");
		end else begin
			$display("complex_running_stats_top_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/crs_pkg.sv
hw/rtl/crs_mac.sv
hw/rtl/crs_div.sv
hw/rtl/complex_running_stats_top.sv
tb/complex_running_stats_top_tb.sv
